// ===== rtl/core/sbsr_pkg.sv =====
// Shared types, codes and constants for the single-wire sensor reader.
// No dependencies; the interfaces and the top level use it.
`default_nettype none

package sbsr_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned CntW      = 6;
  localparam int unsigned TimerW    = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_DRIVE_LOW = 3'd1;
  localparam logic [2:0] PH_DRIVE_HI  = 3'd2;
  localparam logic [2:0] PH_RESP_HI0  = 3'd3;
  localparam logic [2:0] PH_RESP_LOW  = 3'd4;
  localparam logic [2:0] PH_RESP_HI1  = 3'd5;
  localparam logic [2:0] PH_BIT_LOW   = 3'd6;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd7;

  // line drive codes
  localparam logic [1:0] DRV_RELEASE = 2'd0;
  localparam logic [1:0] DRV_LOW     = 2'd1;
  localparam logic [1:0] DRV_HIGH    = 2'd2;

  // read status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_LOW = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESP_TO   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_ONE_THR   = 8'd3;

  // configuration reset values
  localparam logic [15:0] StartLowRst = 16'd20000;
  localparam logic [7:0]  ReleaseRst  = 8'd40;
  localparam logic [7:0]  RespToRst   = 8'd80;
  localparam logic [7:0]  OneThrRst   = 8'd40;

  typedef struct packed {
    logic command;
    logic pin_level;
  } req_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] hum_int;
    logic [7:0] hum_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbsr_if.sv =====
// Valid/ready channel interfaces for the sensor reader: request, result, config.
// Depends on sbsr_pkg for the payload types.
`default_nettype none

interface sbsr_req_if;
  logic          valid;
  logic          ready;
  sbsr_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbsr_res_if;
  logic          valid;
  logic          ready;
  sbsr_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbsr_cfg_if;
  logic          valid;
  logic          ready;
  sbsr_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/single_bus_sensor_reader_top.sv =====
// Single-wire humidity/temperature sensor read master, one tick request per cycle unless stalled.
// Depends on sbsr_pkg and the channel interfaces in sbsr_if.sv.
//
//  channel | dir | payload                              | accepted when
//  req_i   | in  | command, pin_level                   | valid & ready
//  res_o   | out | line_drive, busy, done, status, data | valid & ready
//  cfg_i   | in  | index, data                          | valid (ready tied high)
//
// For each request, the next state and the result are computed
// from the state registers and the request, and land in the state and the
// result register at the accept edge. A new request is taken every cycle
// while the result register is empty or being drained. Reset idles the
// sequencer, clears held data and loads the default configuration.
`default_nettype none

module single_bus_sensor_reader_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  sbsr_req_if.sink     req_i,
  sbsr_res_if.source   res_o,
  sbsr_cfg_if.sink     cfg_i
);

  logic [2:0]                      phase_q, phase_d;
  logic [sbsr_pkg::TimerW-1:0]     timer_q, timer_d;
  logic [sbsr_pkg::CntW-1:0]       bit_cnt_q, bit_cnt_d;
  logic [sbsr_pkg::FrameBits-1:0]  frame_q, frame_d;
  logic [15:0]                     hum_q, hum_d;
  logic [15:0]                     temp_q, temp_d;
  logic [1:0]                      status_q, status_d;
  logic                            done_d;

  logic [15:0] start_low_q;
  logic [7:0]  release_q, resp_to_q, one_thr_q;

  logic                  res_valid_q;
  sbsr_pkg::res_t        res_q, res_d;

  logic                            req_acc;
  logic [sbsr_pkg::TimerW-1:0]     timer_inc;
  logic                            overrun;
  logic                            bit_val;
  logic [sbsr_pkg::FrameBits-1:0]  frame_sh;
  logic [sbsr_pkg::CntW-1:0]       cnt_inc;
  logic [7:0]                      csum;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign timer_inc = timer_q + 16'd1;
  assign overrun   = timer_inc > {8'd0, resp_to_q};
  assign bit_val   = timer_q > {8'd0, one_thr_q};
  assign frame_sh  = {frame_q[sbsr_pkg::FrameBits-2:0], bit_val};
  assign cnt_inc   = bit_cnt_q + 6'd1;
  assign csum      = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    bit_cnt_d = bit_cnt_q;
    frame_d   = frame_q;
    hum_d     = hum_q;
    temp_d    = temp_q;
    status_d  = status_q;
    done_d    = 1'b0;
    if (req_i.payload.command) begin
      phase_d   = sbsr_pkg::PH_DRIVE_LOW;
      timer_d   = '0;
      bit_cnt_d = '0;
      frame_d   = '0;
    end else begin
      unique case (phase_q)
        sbsr_pkg::PH_DRIVE_LOW: begin
          timer_d = timer_inc;
          if (timer_inc >= start_low_q) begin
            phase_d = sbsr_pkg::PH_DRIVE_HI;
            timer_d = '0;
          end
        end
        sbsr_pkg::PH_DRIVE_HI: begin
          timer_d = timer_inc;
          if (timer_inc >= {8'd0, release_q}) begin
            phase_d = sbsr_pkg::PH_RESP_HI0;
            timer_d = '0;
          end
        end
        sbsr_pkg::PH_RESP_HI0, sbsr_pkg::PH_RESP_LOW, sbsr_pkg::PH_RESP_HI1: begin
          // expected level: high, low, high; leaving it advances
          if (req_i.payload.pin_level == (phase_q == sbsr_pkg::PH_RESP_LOW)) begin
            phase_d = phase_q + 3'd1;
            timer_d = '0;
          end else if (overrun) begin
            phase_d  = sbsr_pkg::PH_IDLE;
            timer_d  = '0;
            status_d = sbsr_pkg::ST_TIMEOUT;
            done_d   = 1'b1;
          end else begin
            timer_d = timer_inc;
          end
        end
        sbsr_pkg::PH_BIT_LOW: begin
          if (req_i.payload.pin_level) begin
            phase_d = sbsr_pkg::PH_BIT_HIGH;
            timer_d = 16'd1;
          end
        end
        sbsr_pkg::PH_BIT_HIGH: begin
          if (req_i.payload.pin_level) begin
            if (timer_q != 16'hFFFF) timer_d = timer_inc;
          end else begin
            frame_d   = frame_sh;
            bit_cnt_d = cnt_inc;
            timer_d   = '0;
            if (cnt_inc >= sbsr_pkg::CntW'(sbsr_pkg::FrameBits)) begin
              phase_d = sbsr_pkg::PH_IDLE;
              done_d  = 1'b1;
              if (csum == frame_sh[7:0]) begin
                hum_d    = frame_sh[39:24];
                temp_d   = frame_sh[23:8];
                status_d = sbsr_pkg::ST_OK;
              end else begin
                status_d = sbsr_pkg::ST_CHECKSUM;
              end
            end else begin
              phase_d = sbsr_pkg::PH_BIT_LOW;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d = '0;
    unique case (phase_d)
      sbsr_pkg::PH_DRIVE_LOW: res_d.line_drive = sbsr_pkg::DRV_LOW;
      sbsr_pkg::PH_DRIVE_HI:  res_d.line_drive = sbsr_pkg::DRV_HIGH;
      default:                res_d.line_drive = sbsr_pkg::DRV_RELEASE;
    endcase
    res_d.busy_res  = phase_d != sbsr_pkg::PH_IDLE;
    res_d.done_res  = done_d;
    res_d.status    = status_d;
    res_d.hum_int   = hum_d[15:8];
    res_d.hum_frac  = hum_d[7:0];
    res_d.temp_int  = temp_d[15:8];
    res_d.temp_frac = temp_d[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sbsr_pkg::PH_IDLE;
      timer_q   <= '0;
      bit_cnt_q <= '0;
      frame_q   <= '0;
      hum_q     <= '0;
      temp_q    <= '0;
      status_q  <= sbsr_pkg::ST_OK;
    end else if (req_acc) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_cnt_q <= bit_cnt_d;
      frame_q   <= frame_d;
      hum_q     <= hum_d;
      temp_q    <= temp_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= sbsr_pkg::StartLowRst;
      release_q   <= sbsr_pkg::ReleaseRst;
      resp_to_q   <= sbsr_pkg::RespToRst;
      one_thr_q   <= sbsr_pkg::OneThrRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        sbsr_pkg::CFG_START_LOW: start_low_q <= cfg_i.payload.data;
        sbsr_pkg::CFG_RELEASE:   release_q   <= cfg_i.payload.data[7:0];
        sbsr_pkg::CFG_RESP_TO:   resp_to_q   <= cfg_i.payload.data[7:0];
        sbsr_pkg::CFG_ONE_THR:   one_thr_q   <= cfg_i.payload.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

`ifndef SYNTHESIS
  a_start_enters_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.payload.command) |=> (phase_q == sbsr_pkg::PH_DRIVE_LOW))
    else $error("start request did not enter drive-low phase");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("done reported while still busy");
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.line_drive != sbsr_pkg::DRV_RELEASE)) |-> res_q.busy_res)
    else $error("line driven while idle");
  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= sbsr_pkg::CntW'(sbsr_pkg::FrameBits))
    else $error("bit counter past frame length");
  a_hold_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_acc |=> ($stable(phase_q) && $stable(frame_q) && $stable(status_q)))
    else $error("state changed without a request");
`endif

endmodule

`default_nettype wire
